FILE: sv/pkc_pkg.sv
// power key controller package: register indexes, key event codes, reset values
package pkc_pkg;

	localparam int unsigned TIMER_BITS_DEF = 16;

	localparam int unsigned CFG_IDX_BITS  = 3;
	localparam int unsigned CFG_DATA_BITS = 16;
	localparam int unsigned PERIOD_BITS   = 8;
	localparam int unsigned TIME_BITS     = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_POLL_PERIOD = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_MIN   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WAKE_HOLD   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFF_DELAY   = 3'd4;

	localparam logic [PERIOD_BITS-1:0] POLL_PERIOD_RST = 8'd5;
	localparam logic [TIME_BITS-1:0]   LONG_PRESS_RST  = 16'd1000;
	localparam logic [TIME_BITS-1:0]   SHORT_MIN_RST   = 16'd1;
	localparam logic [TIME_BITS-1:0]   WAKE_HOLD_RST   = 16'd5000;
	localparam logic [TIME_BITS-1:0]   OFF_DELAY_RST   = 16'd3000;

	typedef logic [1:0] key_kind_t;
	localparam key_kind_t KEY_NONE    = 2'd0;
	localparam key_kind_t KEY_LONG    = 2'd1;
	localparam key_kind_t KEY_SHORT   = 2'd2;
	localparam key_kind_t KEY_INVALID = 2'd3;

endpackage

FILE: sv/power_key_controller_top.sv
// power key controller top level: poll register, key classification and power state
//
// one item is one poll of the power key (key_down); each poll gives exactly one result
// item carrying the power state, the mcu and rf supply enables, beep and led-off pulses
// and the key event (none, long press, short press)
// both channels use valid/ready; an item is taken in the poll register, and the state
// update then runs on it and the result is written to the output register once that is free
// throughput is one item per cycle while the receiver does not stall, set by the single
// state update between poll and output registers
// when the receiver stalls the output register holds its item, the poll register
// still takes one more item, and in_ready drops only when both are full
// configuration is written through wr_en / wr_index / wr_data; the user is to write it
// only while idle (not enforced by the block); indexes beyond the register list are ignored
// reset (arst_n low) clears the pipeline, returns the block to power off with both
// supplies disabled and restores the register defaults
module power_key_controller_top #(
	parameter int unsigned TIMER_BITS = pkc_pkg::TIMER_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [pkc_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic [pkc_pkg::CFG_DATA_BITS-1:0] wr_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             key_down,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             power_on,
	output logic                             mcu_power,
	output logic                             rf_power,
	output logic                             beep_start,
	output logic                             leds_off,
	output logic [1:0]                       key_event
);

	localparam int unsigned CW = (TIMER_BITS > pkc_pkg::TIME_BITS) ?
		TIMER_BITS : pkc_pkg::TIME_BITS;
	localparam logic [TIMER_BITS:0] TIMER_MAX = {1'b0, {TIMER_BITS{1'b1}}};

	logic [pkc_pkg::PERIOD_BITS-1:0] poll_period_q;
	logic [pkc_pkg::TIME_BITS-1:0]   long_press_q;
	logic [pkc_pkg::TIME_BITS-1:0]   short_min_q;
	logic [pkc_pkg::TIME_BITS-1:0]   wake_hold_q;
	logic [pkc_pkg::TIME_BITS-1:0]   off_delay_q;

	logic                power_state_q;
	logic                press_active_q;
	logic                long_latched_q;
	pkc_pkg::key_kind_t  pending_kind_q;
	logic [TIMER_BITS-1:0] press_timer_q;
	logic                asleep_q;
	logic                mcu_enable_q;
	logic                rf_enable_q;

	logic valid_s1;
	logic key_s1;
	logic advance;

	logic                  n_power;
	logic                  n_active;
	logic                  n_latched;
	pkc_pkg::key_kind_t    n_pending;
	logic [TIMER_BITS-1:0] n_timer;
	logic                  n_asleep;
	logic                  n_mcu;
	logic                  n_rf;
	logic                  n_beep;
	logic                  n_leds;
	pkc_pkg::key_kind_t    n_event;

	logic [TIMER_BITS:0]   timer_sum;
	logic [CW-1:0]         t_ext;
	logic                  short_taken;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || !out_valid || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_period_q <= pkc_pkg::POLL_PERIOD_RST;
			long_press_q  <= pkc_pkg::LONG_PRESS_RST;
			short_min_q   <= pkc_pkg::SHORT_MIN_RST;
			wake_hold_q   <= pkc_pkg::WAKE_HOLD_RST;
			off_delay_q   <= pkc_pkg::OFF_DELAY_RST;
		end else if (wr_en) begin
			case (wr_index)
				pkc_pkg::REG_POLL_PERIOD: poll_period_q <= wr_data[pkc_pkg::PERIOD_BITS-1:0];
				pkc_pkg::REG_LONG_PRESS:  long_press_q  <= wr_data;
				pkc_pkg::REG_SHORT_MIN:   short_min_q   <= wr_data;
				pkc_pkg::REG_WAKE_HOLD:   wake_hold_q   <= wr_data;
				pkc_pkg::REG_OFF_DELAY:   off_delay_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// poll register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_s1 <= key_down;
		end
	end

	assign timer_sum = {1'b0, press_timer_q}
		+ {{(TIMER_BITS + 1 - pkc_pkg::PERIOD_BITS){1'b0}}, poll_period_q};

	always_comb begin
		n_power     = power_state_q;
		n_active    = press_active_q;
		n_latched   = long_latched_q;
		n_pending   = pending_kind_q;
		n_asleep    = asleep_q;
		n_mcu       = mcu_enable_q;
		n_rf        = rf_enable_q;
		n_beep      = 1'b0;
		n_leds      = 1'b0;
		n_event     = pkc_pkg::KEY_NONE;
		short_taken = 1'b0;

		// press timer
		if (key_s1 && !press_active_q) begin
			n_active = 1'b1;
			n_timer  = '0;
		end else if (timer_sum > TIMER_MAX) begin
			n_timer = TIMER_MAX[TIMER_BITS-1:0];
		end else begin
			n_timer = timer_sum[TIMER_BITS-1:0];
		end
		t_ext = CW'(n_timer);

		// key classification
		if (n_active) begin
			if (!key_s1) begin
				n_active  = 1'b0;
				n_latched = 1'b0;
				if (t_ext > CW'(short_min_q) && t_ext < CW'(long_press_q) && !power_state_q) begin
					n_pending   = pkc_pkg::KEY_SHORT;
					n_event     = pkc_pkg::KEY_SHORT;
					short_taken = 1'b1;
				end
			end
			if (!short_taken && key_s1 && t_ext > CW'(long_press_q) && !n_latched) begin
				n_latched = 1'b1;
				n_pending = pkc_pkg::KEY_LONG;
				n_event   = pkc_pkg::KEY_LONG;
			end
		end

		// pending key
		case (n_pending)
			pkc_pkg::KEY_LONG: begin
				n_power   = !power_state_q;
				n_beep    = 1'b1;
				n_pending = pkc_pkg::KEY_NONE;
				if (!power_state_q) begin
					n_mcu    = 1'b1;
					n_rf     = 1'b1;
					n_asleep = 1'b0;
				end else begin
					n_leds = 1'b1;
					n_rf   = 1'b0;
					n_mcu  = 1'b0;
				end
			end
			pkc_pkg::KEY_SHORT: begin
				if (t_ext < CW'(wake_hold_q)) begin
					n_mcu = 1'b1;
				end
			end
			pkc_pkg::KEY_INVALID: n_pending = pkc_pkg::KEY_NONE;
			default: ;
		endcase

		// off state supervision
		if (!n_power) begin
			n_rf = 1'b0;
			if (!n_asleep && t_ext > CW'(off_delay_q)) begin
				n_leds   = 1'b1;
				n_mcu    = 1'b0;
				n_asleep = 1'b1;
			end
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_state_q  <= 1'b0;
			press_active_q <= 1'b0;
			long_latched_q <= 1'b0;
			pending_kind_q <= pkc_pkg::KEY_NONE;
			press_timer_q  <= '0;
			asleep_q       <= 1'b0;
			mcu_enable_q   <= 1'b0;
			rf_enable_q    <= 1'b0;
		end else if (advance) begin
			power_state_q  <= n_power;
			press_active_q <= n_active;
			long_latched_q <= n_latched;
			pending_kind_q <= n_pending;
			press_timer_q  <= n_timer;
			asleep_q       <= n_asleep;
			mcu_enable_q   <= n_mcu;
			rf_enable_q    <= n_rf;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			power_on   <= n_power;
			mcu_power  <= n_mcu;
			rf_power   <= n_rf;
			beep_start <= n_beep;
			leds_off   <= n_leds;
			key_event  <= n_event;
		end
	end

endmodule

FILE: sv/pkc_checker.sv
// power key controller port checker and its bind to the top level
module pkc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       power_on,
	input logic       mcu_power,
	input logic       rf_power,
	input logic       beep_start,
	input logic       leds_off,
	input logic [1:0] key_event
);

	// a stalled result item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({power_on, mcu_power, rf_power,
			beep_start, leds_off, key_event}))
		else $error("stalled result item changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> key_event != pkc_pkg::KEY_INVALID)
		else $error("undefined key event");

	// a long press always toggles power and beeps; only the beep is asserted here
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_event == pkc_pkg::KEY_LONG |-> beep_start)
		else $error("long press without beep");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_event == pkc_pkg::KEY_SHORT |-> !power_on && !beep_start)
		else $error("short press while on or with beep");

	// rf only while on, leds switched off only while off
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!rf_power || power_on) && (!leds_off || !power_on))
		else $error("supply or led pulse inconsistent with power state");

endmodule

bind power_key_controller_top pkc_checker u_pkc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.power_on   (power_on),
	.mcu_power  (mcu_power),
	.rf_power   (rf_power),
	.beep_start (beep_start),
	.leds_off   (leds_off),
	.key_event  (key_event)
);

FILE: tb/pkc_result_check.sv
`timescale 1ns / 1ps
// power key controller checker: predicts the result of every poll item and compares it
module pkc_result_check
	import pkc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [CFG_IDX_BITS-1:0]  wr_index,
	input  logic [CFG_DATA_BITS-1:0] wr_data,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic                     key_down,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic                     power_on,
	input  logic                     mcu_power,
	input  logic                     rf_power,
	input  logic                     beep_start,
	input  logic                     leds_off,
	input  logic [1:0]               key_event,
	output int                       fail_count,
	output int                       polls_in_flight
);

	typedef struct packed {
		logic      power_on;
		logic      mcu_power;
		logic      rf_power;
		logic      beep_start;
		logic      leds_off;
		key_kind_t key_event;
	} poll_result_t;

	logic [PERIOD_BITS-1:0]    poll_period;
	logic [TIME_BITS-1:0]      long_press;
	logic [TIME_BITS-1:0]      short_min;
	logic [TIME_BITS-1:0]      wake_hold;
	logic [TIME_BITS-1:0]      off_delay;

	logic                      power_state;
	logic                      press_active;
	logic                      long_latched;
	key_kind_t                 pending_kind;
	logic [TIMER_BITS_DEF-1:0] press_timer;
	logic                      asleep;
	logic                      mcu_en;
	logic                      rf_en;

	poll_result_t              power_results_q[$];

	initial fail_count = 0;
	initial polls_in_flight = 0;

	function automatic poll_result_t next_power_result(input logic key);
		poll_result_t          r;
		logic [TIMER_BITS_DEF:0] sum;
		logic                  short_taken;
		r = '0;
		short_taken = 1'b0;

		if (key && !press_active) begin
			press_active = 1'b1;
			press_timer = '0;
		end else begin
			sum = {1'b0, press_timer} + poll_period;
			press_timer = sum[TIMER_BITS_DEF] ? '1 : sum[TIMER_BITS_DEF-1:0];
		end

		if (press_active) begin
			if (!key) begin
				press_active = 1'b0;
				long_latched = 1'b0;
				if (press_timer > short_min && press_timer < long_press && !power_state) begin
					pending_kind = KEY_SHORT;
					r.key_event = KEY_SHORT;
					short_taken = 1'b1;
				end
			end
			if (!short_taken && key && press_timer > long_press && !long_latched) begin
				long_latched = 1'b1;
				pending_kind = KEY_LONG;
				r.key_event = KEY_LONG;
			end
		end

		case (pending_kind)
			KEY_LONG: begin
				power_state = !power_state;
				r.beep_start = 1'b1;
				pending_kind = KEY_NONE;
				if (power_state) begin
					mcu_en = 1'b1;
					rf_en = 1'b1;
					asleep = 1'b0;
				end else begin
					r.leds_off = 1'b1;
					rf_en = 1'b0;
					mcu_en = 1'b0;
				end
			end
			KEY_SHORT: begin
				if (press_timer < wake_hold)
					mcu_en = 1'b1;
			end
			KEY_INVALID: begin
				pending_kind = KEY_NONE;
			end
			default: begin
			end
		endcase

		if (!power_state) begin
			rf_en = 1'b0;
			if (!asleep && press_timer > off_delay) begin
				r.leds_off = 1'b1;
				mcu_en = 1'b0;
				asleep = 1'b1;
			end
		end

		r.power_on = power_state;
		r.mcu_power = mcu_en;
		r.rf_power = rf_en;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track_polls
		poll_result_t exp_r;
		if (!arst_n) begin
			poll_period = POLL_PERIOD_RST;
			long_press = LONG_PRESS_RST;
			short_min = SHORT_MIN_RST;
			wake_hold = WAKE_HOLD_RST;
			off_delay = OFF_DELAY_RST;
			power_state = 1'b0;
			press_active = 1'b0;
			long_latched = 1'b0;
			pending_kind = KEY_NONE;
			press_timer = '0;
			asleep = 1'b0;
			mcu_en = 1'b0;
			rf_en = 1'b0;
			power_results_q.delete();
			polls_in_flight = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_POLL_PERIOD: poll_period = wr_data[PERIOD_BITS-1:0];
					REG_LONG_PRESS:  long_press = wr_data[TIME_BITS-1:0];
					REG_SHORT_MIN:   short_min = wr_data[TIME_BITS-1:0];
					REG_WAKE_HOLD:   wake_hold = wr_data[TIME_BITS-1:0];
					REG_OFF_DELAY:   off_delay = wr_data[TIME_BITS-1:0];
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (power_results_q.size() == 0) begin
					$error("result item with no poll waiting for it");
					fail_count++;
				end else begin
					exp_r = power_results_q.pop_front();
					check_field("power_on", exp_r.power_on, power_on);
					check_field("mcu_power", exp_r.mcu_power, mcu_power);
					check_field("rf_power", exp_r.rf_power, rf_power);
					check_field("beep_start", exp_r.beep_start, beep_start);
					check_field("leds_off", exp_r.leds_off, leds_off);
					check_field("key_event", exp_r.key_event, key_event);
				end
			end
			if (in_valid && in_ready)
				power_results_q.push_back(next_power_result(key_down));
			polls_in_flight = power_results_q.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// power key controller testbench top: clock, reset, poll and register stimulus, verdict
module tb_top;
	import pkc_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic                     clk;
	logic                     arst_n;
	logic                     wr_en;
	logic [CFG_IDX_BITS-1:0]  wr_index;
	logic [CFG_DATA_BITS-1:0] wr_data;
	logic                     in_valid;
	logic                     in_ready;
	logic                     key_down;
	logic                     out_valid;
	logic                     out_ready;
	logic                     power_on;
	logic                     mcu_power;
	logic                     rf_power;
	logic                     beep_start;
	logic                     leds_off;
	logic [1:0]               key_event;

	int                       fail_count;
	int                       polls_in_flight;
	int                       idle_cycles = 0;
	int                       stall_left;
	bit                       tx_gaps;
	bit                       rx_gaps;
	bit                       hold_req;
	int unsigned              period_ms;
	int unsigned              long_ms;
	int unsigned              wake_ms;
	int unsigned              off_ms;

	power_key_controller_top dut (.*);

	pkc_result_check result_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: short random stalls, or one long hold-off on request
	initial begin
		out_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0)
				stall_left--;
			else if (hold_req) begin
				stall_left = 40;
				hold_req = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 4);
			out_ready <= (stall_left == 0);
		end
	end

	task automatic send_poll(input logic k);
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		key_down <= k;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
	endtask

	task automatic load_timing(input int unsigned p, input int unsigned lp, input int unsigned sm,
		input int unsigned wh, input int unsigned od);
		period_ms = p;
		long_ms = lp;
		wake_ms = wh;
		off_ms = od;
		write_reg(REG_POLL_PERIOD, {8'($urandom_range(0, 255)), 8'(p)});
		write_reg(REG_LONG_PRESS, 16'(lp));
		write_reg(REG_SHORT_MIN, 16'(sm));
		write_reg(REG_WAKE_HOLD, 16'(wh));
		write_reg(REG_OFF_DELAY, 16'(od));
		write_reg(3'($urandom_range(5, 7)), 16'($urandom()));
		wr_en <= 1'b0;
	endtask

	task automatic random_timing();
		int unsigned p;
		p = $urandom_range(1, 255);
		load_timing(p, p * $urandom_range(2, 12) + $urandom_range(0, p - 1),
			p * $urandom_range(0, 2) + $urandom_range(0, p - 1),
			p * $urandom_range(0, 40), p * $urandom_range(0, 30));
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		while (polls_in_flight != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// mostly press and release sequences sized around the thresholds, some noise
	task automatic run_phase(input int unsigned target);
		int unsigned sent;
		int unsigned hold;
		int unsigned rel;
		int unsigned lp_polls;
		int unsigned rel_max;
		sent = 0;
		lp_polls = long_ms / period_ms + 1;
		rel_max = ((wake_ms > off_ms) ? wake_ms : off_ms) / period_ms + 3;
		if (rel_max > 300)
			rel_max = 300;
		while (sent < target) begin
			if ($urandom_range(0, 9) < 8) begin
				if ($urandom_range(0, 1))
					hold = $urandom_range(lp_polls + 1, lp_polls + 3);
				else
					hold = $urandom_range(1, lp_polls);
				rel = $urandom_range(1, rel_max);
				repeat (hold) send_poll(1'b1);
				repeat (rel) send_poll(1'b0);
				sent += hold + rel;
			end else begin
				hold = $urandom_range(1, 6);
				repeat (hold) send_poll(1'($urandom_range(0, 1)));
				sent += hold;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		key_down = 1'b0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		hold_req = 1'b0;
		period_ms = POLL_PERIOD_RST;
		long_ms = LONG_PRESS_RST;
		wake_ms = WAKE_HOLD_RST;
		off_ms = OFF_DELAY_RST;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// reset timing: timer running from reset, then short presses while off
		repeat (3) send_poll(1'b0);
		send_poll(1'b1);
		repeat (3) send_poll(1'b0);
		send_poll(1'b1);
		send_poll(1'b0);

		// fast timing: long press on, long press off, then the sleep step after the off delay
		go_idle();
		load_timing(255, 1, 0, 600, 300);
		repeat (3) send_poll(1'b1);
		repeat (2) send_poll(1'b0);
		repeat (2) send_poll(1'b1);
		repeat (3) send_poll(1'b0);

		for (int ph = 0; ph < 8; ph++) begin
			go_idle();
			case (ph)
				0: load_timing(1, 1, 0, 0, 0);
				1: load_timing(255, 65535, 65535, 65535, 65535);
				default: random_timing();
			endcase
			if (ph == 2)
				hold_req = 1'b1;
			if (ph == 7) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end
			run_phase((ph == 1) ? 200 : 120);
		end

		in_valid <= 1'b0;
		while (polls_in_flight != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0 && polls_in_flight == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
